/* rtl/dsp_pkg.sv */
// dsp_pkg: shared types and codes for the shortest path block
// no dependencies
`default_nettype none
package dsp_pkg;
	localparam logic ACT_EDGE  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic        action;
		logic [5:0]  from_vertex;
		logic [5:0]  to_vertex;
		logic [15:0] edge_weight;
		logic        edge_present;
	} dsp_in_t;

	typedef struct packed {
		logic [5:0]  path_vertex;
		logic [23:0] total_weight;
		logic        reachable;
		logic        last;
	} dsp_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_INIT, ST_SEL, ST_SEL_END, ST_RLX_RD, ST_RLX,
		ST_WALK_RD, ST_WALK, ST_EMIT_RD, ST_EMIT, ST_FAIL
	} dsp_state_t;
endpackage
`default_nettype wire

/* rtl/dsp_ram.sv */
// dsp_ram: generic single port write, single port read ram, registered read
// no dependencies
`default_nettype none
module dsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/dijkstra_shortest_path.sv */
// dijkstra_shortest_path: top level, adjacency store, sequencer and compare unit
// depends on dsp_pkg and dsp_ram
//
// channel  dir  handshake         payload
// in       in   start / busy      in  (dsp_in_t)
// out      out  out_valid strobe  out (dsp_out_t)
// cfg      in   cfg_valid/ready   cfg_data (vertex_count), taken only while idle
//
// an edge write keeps busy high through the ST_WALK state after its accepting edge; a
// query keeps it high through init, select and relax rounds, walk and emit, with one
// distance compare per cycle in the select scan and one adjacency read per relax step;
// a bad endpoint or unreachable destination takes ST_FAIL. after reset a clearing pass
// over every edge store entry keeps busy high and wipes edge presence.
// results are strobed on out_valid, one per ST_EMIT or ST_FAIL state, and cannot be stalled.
`default_nettype none
module dijkstra_shortest_path import dsp_pkg::*; #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16,
	parameter int DIST_BITS    = 24
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire dsp_in_t  in,
	output logic          out_valid,
	output dsp_out_t      out,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	input  wire logic [6:0] cfg_data
);
	localparam int VB = $clog2(MAX_VERTICES);
	localparam int EB = 2 * VB;
	localparam int ED = 1 << EB;
	localparam int CB = VB + 1;
	localparam logic [DIST_BITS-1:0] DMAX = '1;
	localparam int EW = WEIGHT_BITS + 1;
	localparam int SW = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

	dsp_state_t st_q, st_d;
	logic [6:0] vcount_q;
	logic [CB-1:0] n_eff;
	logic [EB-1:0] clr_q;
	logic [VB-1:0] org_q, dst_q, u_q, best_q;
	logic [CB-1:0] i_q, round_q, len_q;
	logic best_ok_q;
	logic [DIST_BITS-1:0] bd_q, du_q;
	logic [MAX_VERTICES-1:0] settled_q, reached_q;
	logic [5:0] v_q;

	// edge store: presence and weight in one word
	logic e_we;
	logic [EB-1:0] e_wa, e_ra;
	logic [EW-1:0] e_wd, e_rd;
	// distance store
	logic d_we;
	logic [VB-1:0] d_wa, d_ra;
	logic [DIST_BITS-1:0] d_wd, d_rd;
	// predecessor store
	logic p_we;
	logic [VB-1:0] p_wa, p_ra, p_rd, p_wd_w;
	// path buffer
	logic b_we;
	logic [VB-1:0] b_wa, b_ra, b_wd, b_rd;

	logic [VB-1:0] iv;
	logic [SW-1:0] nd_sum;
	logic [DIST_BITS-1:0] nd;
	logic accept, i_end;
	logic [VB-1:0] lm1;
	logic cand_last, sel_ok;
	logic [VB-1:0] sel_v;

	dsp_ram #(.WIDTH(EW), .DEPTH(ED)) u_edge (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
	dsp_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
	dsp_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_pred (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd_w), .raddr(p_ra), .rdata(p_rd));
	dsp_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_path (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

	assign iv     = i_q[VB-1:0];
	assign i_end  = (i_q == n_eff - CB'(1));
	assign accept = start && !busy;
	assign busy   = (st_q != ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE) && !start;
	assign lm1    = VB'(len_q - CB'(1) - i_q);

	// last selection candidate, its distance is read back in ST_SEL_END after the scan
	assign cand_last = reached_q[iv] && !settled_q[iv] && (!best_ok_q || d_rd <= bd_q);
	assign sel_ok    = best_ok_q || cand_last;
	assign sel_v     = cand_last ? iv : best_q;

	// shared adder with saturation
	always_comb begin
		nd_sum = SW'(du_q) + SW'(e_rd[WEIGHT_BITS-1:0]);
		nd = (nd_sum > SW'(DMAX)) ? DMAX : nd_sum[DIST_BITS-1:0];
	end

	// sequencer next state and store controls
	always_comb begin
		st_d = st_q;
		e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = {u_q, iv};
		d_we = 1'b0; d_wa = iv; d_wd = DMAX; d_ra = iv;
		p_we = 1'b0; p_wa = iv; p_wd_w = u_q; p_ra = v_q[VB-1:0];
		b_we = 1'b0; b_wa = len_q[VB-1:0]; b_wd = v_q[VB-1:0]; b_ra = lm1;
		unique case (st_q)
			ST_CLEAR: begin
				e_we = 1'b1; e_wa = clr_q;
				if (&clr_q) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && in.action == ACT_EDGE) begin
					if (7'(in.from_vertex) < 7'(MAX_VERTICES)
						&& 7'(in.to_vertex) < 7'(MAX_VERTICES)) begin
						e_we = 1'b1;
						e_wa = {in.from_vertex[VB-1:0], in.to_vertex[VB-1:0]};
						e_wd = {in.edge_present, WEIGHT_BITS'(in.edge_weight)};
					end
					st_d = ST_WALK; // passes through ST_WALK, leaves via len check below
				end else if (accept) begin
					if (7'(in.from_vertex) >= 7'(n_eff) || 7'(in.to_vertex) >= 7'(n_eff))
						st_d = ST_FAIL;
					else st_d = ST_INIT;
				end
			end
			ST_INIT: begin
				d_we = 1'b1; d_wd = (iv == org_q) ? '0 : DMAX;
				if (i_end) st_d = ST_SEL;
			end
			ST_SEL: begin
				if (i_end) st_d = ST_SEL_END;
			end
			ST_SEL_END: begin
				d_ra = sel_v;
				if (!sel_ok || round_q == n_eff) begin
					st_d = reached_q[dst_q] ? ST_WALK_RD : ST_FAIL;
				end else st_d = ST_RLX_RD;
			end
			ST_RLX_RD: st_d = ST_RLX;
			ST_RLX: begin
				if (e_rd[WEIGHT_BITS] && !settled_q[iv] && (!reached_q[iv] || nd < d_rd)) begin
					d_we = 1'b1; d_wd = nd; p_we = 1'b1;
				end
				if (i_end) st_d = ST_SEL;
				else st_d = ST_RLX_RD;
			end
			ST_WALK_RD: begin
				b_we = 1'b1;
				d_ra = dst_q;
				if (v_q[VB-1:0] == org_q || len_q + CB'(1) == n_eff) st_d = ST_EMIT_RD;
				else st_d = ST_WALK;
			end
			ST_WALK: begin
				if (len_q == '0) st_d = ST_IDLE;
				else st_d = ST_WALK_RD;
			end
			ST_EMIT_RD: st_d = ST_EMIT;
			ST_EMIT: begin
				if (i_q + CB'(1) == len_q) st_d = ST_IDLE;
				else st_d = ST_EMIT_RD;
			end
			ST_FAIL: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			vcount_q <= 7'd32;
			out_valid <= 1'b0;
			out <= '0;
			len_q <= '0;
			org_q <= '0;
			dst_q <= '0;
			u_q <= '0;
			best_q <= '0;
			i_q <= '0;
			round_q <= '0;
			best_ok_q <= 1'b0;
			bd_q <= '0;
			du_q <= '0;
			settled_q <= '0;
			reached_q <= '0;
			v_q <= '0;
		end else begin
			st_q <= st_d;
			out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					len_q <= '0;
					org_q <= in.from_vertex[VB-1:0];
					dst_q <= in.to_vertex[VB-1:0];
					v_q <= in.to_vertex;
					i_q <= '0; round_q <= '0;
					settled_q <= '0;
					reached_q <= MAX_VERTICES'(1) << in.from_vertex[VB-1:0];
					best_ok_q <= 1'b0;
				end
				ST_INIT: begin
					i_q <= i_end ? '0 : i_q + 1'b1;
				end
				ST_SEL: begin
					// one distance compare per cycle, read data is registered so it lags the scan index
					if (i_q != '0 && reached_q[iv - 1'b1] && !settled_q[iv - 1'b1]
						&& (!best_ok_q || d_rd <= bd_q)) begin
						best_ok_q <= 1'b1; bd_q <= d_rd; best_q <= iv - 1'b1;
					end
					i_q <= i_end ? i_q : i_q + 1'b1;
				end
				ST_SEL_END: begin
					// settle the winner, last candidate included
					u_q <= sel_v;
					if (sel_ok) settled_q[sel_v] <= 1'b1;
					i_q <= '0;
					round_q <= round_q + 1'b1;
				end
				ST_RLX_RD: begin
					if (i_q == '0) du_q <= d_rd;
				end
				ST_RLX: begin
					if (e_rd[WEIGHT_BITS] && !settled_q[iv] && (!reached_q[iv] || nd < d_rd))
						reached_q[iv] <= 1'b1;
					i_q <= i_end ? '0 : i_q + 1'b1;
					if (i_end) best_ok_q <= 1'b0;
				end
				ST_WALK_RD: begin
					len_q <= len_q + 1'b1;
				end
				ST_WALK: begin
					if (len_q != '0) v_q <= 6'(p_rd);
					i_q <= '0;
				end
				ST_EMIT_RD: begin
					if (i_q == '0 && len_q != '0) bd_q <= d_rd;
				end
				ST_EMIT: begin
					out_valid <= 1'b1;
					out.path_vertex <= 6'(b_rd);
					out.total_weight <= 24'(bd_q);
					out.reachable <= 1'b1;
					out.last <= (i_q + CB'(1) == len_q);
					i_q <= i_q + 1'b1;
				end
				ST_FAIL: begin
					// destination still held from the accepting beat
					out_valid <= 1'b1;
					out.path_vertex <= v_q;
					out.total_weight <= 24'(DMAX);
					out.reachable <= 1'b0;
					out.last <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// effective vertex count, clamped
	always_comb begin
		if (vcount_q == '0) n_eff = CB'(1);
		else if (vcount_q > 7'(MAX_VERTICES)) n_eff = CB'(MAX_VERTICES);
		else n_eff = CB'(vcount_q);
	end
endmodule
`default_nettype wire
